// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the vote volume block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define VVPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define VVPE_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/vvpe_pkg.sv
// Shared types and constants of the vote volume peak extractor.
package vvpe_pkg;

  localparam int COORD_W   = 5;
  localparam int AMT_W     = 24;
  localparam int RAD_W     = 3;
  localparam int REACH_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  typedef enum logic [2:0] {
    KIND_ADD     = 3'd0,
    KIND_SET     = 3'd1,
    KIND_FILL    = 3'd2,
    KIND_READ    = 3'd3,
    KIND_EXTRACT = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_REACH     = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  localparam logic [RAD_W-1:0]   RADIUS_RST    = 3'd3;
  localparam logic [REACH_W-1:0] REACH_RST     = 4'd3;
  localparam logic [AMT_W-1:0]   THRESHOLD_RST = 24'd0;

  // Walker control: load a new box, or step to the next cell of the box.
  typedef struct packed {
    logic start;
    logic advance;
  } walk_ctl_t;

endpackage

// File: rtl/core/vvpe_walker.sv
// Box walker: steps x, y, z coordinates over a box, z fastest, x slowest.
module vvpe_walker import vvpe_pkg::*; #(
  parameter int CW = 5
) (
  input  logic          clk,
  input  walk_ctl_t     ctl,
  input  logic [CW-1:0] lo_x,
  input  logic [CW-1:0] hi_x,
  input  logic [CW-1:0] lo_y,
  input  logic [CW-1:0] hi_y,
  input  logic [CW-1:0] lo_z,
  input  logic [CW-1:0] hi_z,
  output logic [CW-1:0] x,
  output logic [CW-1:0] y,
  output logic [CW-1:0] z,
  output logic          last
);

  logic [CW-1:0] x_r, y_r, z_r;
  logic [CW-1:0] lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;

  // Latch the box on start; carry z into y and y into x on advance.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r    <= lo_x;
      y_r    <= lo_y;
      z_r    <= lo_z;
      lo_y_r <= lo_y;
      lo_z_r <= lo_z;
      hi_x_r <= hi_x;
      hi_y_r <= hi_y;
      hi_z_r <= hi_z;
    end else if (ctl.advance) begin
      if (z_r == hi_z_r) begin
        z_r <= lo_z_r;
        if (y_r == hi_y_r) begin
          y_r <= lo_y_r;
          x_r <= x_r + CW'(1);
        end else begin
          y_r <= y_r + CW'(1);
        end
      end else begin
        z_r <= z_r + CW'(1);
      end
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  assign last = (x_r == hi_x_r) && (y_r == hi_y_r) && (z_r == hi_z_r);

endmodule

// File: rtl/core/vvpe_alu.sv
// Shared value unit: saturating add and strict greater-than compare.
module vvpe_alu #(
  parameter int VW = 24
) (
  input  logic [VW-1:0] op_a,
  input  logic [VW-1:0] op_b,
  output logic [VW-1:0] sat_sum,
  output logic          a_gt_b
);

  logic [VW:0] sum;

  assign sum     = {1'b0, op_a} + {1'b0, op_b};
  // Clamp at all ones on carry out.
  assign sat_sum = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];
  assign a_gt_b  = op_a > op_b;

endmodule

// File: rtl/core/vote_volume_peak_extractor.sv
// Top level of the vote volume peak extractor: sequencer, vote memory, registers.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  in_      | in_valid / in_ready       | kind, cell_x, cell_y, cell_z, amount
//  out_     | out_valid / out_ready     | peak_x/y/z, cell_value, found, above_threshold
//  cfg_     | cfg_wr_en (no wait)       | cfg_index, cfg_wdata
//
// Fill writes the whole volume and extract reads it, one cell a cycle; when a
// peak is found, extract then zeroes the clipped window around it. The vote
// memory has one write port and one registered read port.
// After reset a clearing pass zeroes the memory; in_ready
// stays low until it ends, while configuration writes are taken as ever.
// A read or extract result waits in the output register; the block stalls
// only if a further result is ready while that beat is still untaken.
module vote_volume_peak_extractor import vvpe_pkg::*; #(
  parameter int SIDE       = 32,
  parameter int VALUE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic [COORD_W-1:0]   in_cell_x,
  input  logic [COORD_W-1:0]   in_cell_y,
  input  logic [COORD_W-1:0]   in_cell_z,
  input  logic [AMT_W-1:0]     in_amount,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_peak_x,
  output logic [COORD_W-1:0]   out_peak_y,
  output logic [COORD_W-1:0]   out_peak_z,
  output logic [AMT_W-1:0]     out_cell_value,
  output logic                 out_found,
  output logic                 out_above_threshold,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = $clog2(SIDE);   // coordinate bits inside the volume
  localparam int AW    = 3 * CW;         // memory address: {z, y, x}
  localparam int VW    = VALUE_BITS;
  localparam int EW    = CW + 5;         // room for coordinate plus window reach
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_ADD_WR,
    ST_READ_OUT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SUPP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [RAD_W-1:0]   radius_r;
  logic [REACH_W-1:0] reach_r;
  logic [AMT_W-1:0]   thresh_r;

  // accepted item
  logic [AW-1:0] item_addr_r;
  logic [VW-1:0] item_amt_r;
  logic          item_in_r;

  // scan pipeline and running best
  logic          scan_v_r;
  logic [CW-1:0] scan_x_r, scan_y_r, scan_z_r;
  logic [VW-1:0] best_v_r;
  logic [CW-1:0] best_x_r, best_y_r, best_z_r;

  // output register
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [AMT_W-1:0]   out_value_r;
  logic               out_found_r, out_above_r;

  // vote memory
  logic [VW-1:0] vote_mem [DEPTH];
  logic [VW-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] wr_data;

  // walker and shared unit
  walk_ctl_t     wctl;
  logic          win_sel;
  logic [CW-1:0] walk_x, walk_y, walk_z;
  logic          walk_last;
  logic [AW-1:0] walk_addr;
  logic [CW-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [CW-1:0] wlo_x, whi_x, wlo_y, whi_y, wlo_z, whi_z;
  logic [VW-1:0] alu_b, alu_sum;
  logic          alu_gt;

  logic          accept, out_free, in_inside;
  logic [AW-1:0] in_addr;
  logic [VW-1:0] in_amt;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_inside = (32'(in_cell_x) < 32'(SIDE)) && (32'(in_cell_y) < 32'(SIDE)) &&
                     (32'(in_cell_z) < 32'(SIDE));
  assign in_addr   = {CW'(in_cell_z), CW'(in_cell_y), CW'(in_cell_x)};
  // Mask the amount to the cell width.
  assign in_amt    = VW'(in_amount);
  assign walk_addr = {walk_z, walk_y, walk_x};

  // Suppression window around the peak, clipped to the volume.
  logic [EW-1:0] bx_e, by_e, bz_e, rad_e, reach_e, lim_e;

  assign bx_e    = EW'(best_x_r);
  assign by_e    = EW'(best_y_r);
  assign bz_e    = EW'(best_z_r);
  assign rad_e   = EW'(radius_r);
  assign reach_e = EW'(reach_r);
  assign lim_e   = EW'(SIDE - 1);

  assign wlo_x = (bx_e >= rad_e) ? CW'(bx_e - rad_e) : '0;
  assign wlo_y = (by_e >= rad_e) ? CW'(by_e - rad_e) : '0;
  assign wlo_z = (bz_e >= rad_e) ? CW'(bz_e - rad_e) : '0;
  assign whi_x = (bx_e + rad_e > lim_e) ? CW'(SIDE - 1) : CW'(bx_e + rad_e);
  assign whi_y = (by_e + rad_e > lim_e) ? CW'(SIDE - 1) : CW'(by_e + rad_e);
  assign whi_z = (bz_e + reach_e > lim_e) ? CW'(SIDE - 1) : CW'(bz_e + reach_e);

  // Whole volume unless the window is being loaded.
  assign lo_x = win_sel ? wlo_x : '0;
  assign lo_y = win_sel ? wlo_y : '0;
  assign lo_z = win_sel ? wlo_z : '0;
  assign hi_x = win_sel ? whi_x : CW'(SIDE - 1);
  assign hi_y = win_sel ? whi_y : CW'(SIDE - 1);
  assign hi_z = win_sel ? whi_z : CW'(SIDE - 1);

  vvpe_walker #(.CW(CW)) u_walker (
    .clk  (clk),
    .ctl  (wctl),
    .lo_x (lo_x),
    .hi_x (hi_x),
    .lo_y (lo_y),
    .hi_y (hi_y),
    .lo_z (lo_z),
    .hi_z (hi_z),
    .x    (walk_x),
    .y    (walk_y),
    .z    (walk_z),
    .last (walk_last)
  );

  // Add uses the item's weight; the scan compares against the best so far.
  assign alu_b = (state_r == ST_ADD_WR) ? item_amt_r : best_v_r;

  vvpe_alu #(.VW(VW)) u_alu (
    .op_a    (rd_data_r),
    .op_b    (alu_b),
    .sat_sum (alu_sum),
    .a_gt_b  (alu_gt)
  );

  // Sequencer: memory port and walker control.
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = walk_addr;
    wr_en     = 1'b0;
    wr_addr   = walk_addr;
    wr_data   = item_amt_r;
    wctl      = '0;
    win_sel   = 1'b0;
    case (state_r)
      ST_INIT: begin
        wctl.start = 1'b1;
        state_nxt  = ST_FILL;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_ADD: begin
              if (in_inside) begin
                rd_en     = 1'b1;
                rd_addr   = in_addr;
                state_nxt = ST_ADD_WR;
              end
            end
            KIND_SET: begin
              wr_en   = in_inside;
              wr_addr = in_addr;
              wr_data = in_amt;
            end
            KIND_FILL: begin
              wctl.start = 1'b1;
              state_nxt  = ST_FILL;
            end
            KIND_READ: begin
              rd_en     = 1'b1;
              rd_addr   = in_addr;
              state_nxt = ST_READ_OUT;
            end
            KIND_EXTRACT: begin
              wctl.start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        wr_en        = 1'b1;
        wctl.advance = 1'b1;
        if (walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_WR: begin
        wr_en     = 1'b1;
        wr_addr   = item_addr_r;
        wr_data   = alu_sum;
        state_nxt = ST_IDLE;
      end
      ST_READ_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_en        = 1'b1;
        wctl.advance = 1'b1;
        if (walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (best_v_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          win_sel    = 1'b1;
          wctl.start = 1'b1;
          state_nxt  = ST_SUPP;
        end
      end
      ST_SUPP: begin
        wr_en        = 1'b1;
        wr_data      = '0;
        wctl.advance = 1'b1;
        if (walk_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Vote memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vote_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vote_mem[rd_addr];
    end
  end

  // State, item, scan and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
      radius_r    <= RADIUS_RST;
      reach_r     <= REACH_RST;
      thresh_r    <= THRESHOLD_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_RADIUS:    radius_r <= RAD_W'(cfg_wdata);
          CFG_REACH:     reach_r  <= REACH_W'(cfg_wdata);
          CFG_THRESHOLD: thresh_r <= AMT_W'(cfg_wdata);
          default:       ;
        endcase
      end

      // Raise the output beat on a new load; otherwise drop it once taken.
      if ((state_r == ST_READ_OUT || state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // The clearing pass fills with zero.
      if (state_r == ST_INIT) begin
        item_amt_r <= '0;
      end

      if (accept) begin
        item_addr_r <= in_addr;
        item_amt_r  <= in_amt;
        item_in_r   <= in_inside;
        if (in_kind == KIND_EXTRACT) begin
          best_v_r <= '0;
        end
      end

      // Hold the scanned cell's coordinates alongside its registered read.
      scan_v_r <= (state_r == ST_SCAN);
      scan_x_r <= walk_x;
      scan_y_r <= walk_y;
      scan_z_r <= walk_z;
      if (scan_v_r && alu_gt) begin
        best_v_r <= rd_data_r;
        best_x_r <= scan_x_r;
        best_y_r <= scan_y_r;
        best_z_r <= scan_z_r;
      end

      if (state_r == ST_READ_OUT && out_free) begin
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
        out_value_r <= item_in_r ? AMT_W'(rd_data_r) : '0;
        out_found_r <= 1'b0;
        out_above_r <= 1'b0;
      end

      if (state_r == ST_FINISH && out_free) begin
        if (best_v_r == '0) begin
          out_x_r     <= '0;
          out_y_r     <= '0;
          out_z_r     <= '0;
          out_value_r <= '0;
          out_found_r <= 1'b0;
          out_above_r <= 1'b0;
        end else begin
          out_x_r     <= COORD_W'(best_x_r);
          out_y_r     <= COORD_W'(best_y_r);
          out_z_r     <= COORD_W'(best_z_r);
          out_value_r <= AMT_W'(best_v_r);
          out_found_r <= 1'b1;
          out_above_r <= 32'(best_v_r) > 32'(thresh_r);
        end
      end
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_peak_x          = out_x_r;
  assign out_peak_y          = out_y_r;
  assign out_peak_z          = out_z_r;
  assign out_cell_value      = out_value_r;
  assign out_found           = out_found_r;
  assign out_above_threshold = out_above_r;

endmodule

// File: rtl/core/vvpe_checker.sv
// Port checker of the vote volume peak extractor, bound to the top level.
`include "assert_macros.svh"

module vvpe_checker import vvpe_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [2:0]           in_kind,
  input logic [COORD_W-1:0]   in_cell_x,
  input logic [COORD_W-1:0]   in_cell_y,
  input logic [COORD_W-1:0]   in_cell_z,
  input logic [AMT_W-1:0]     in_amount,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COORD_W-1:0]   out_peak_x,
  input logic [COORD_W-1:0]   out_peak_y,
  input logic [COORD_W-1:0]   out_peak_z,
  input logic [AMT_W-1:0]     out_cell_value,
  input logic                 out_found,
  input logic                 out_above_threshold,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_wdata
);

  // Reset starts the clearing pass: nothing taken, nothing shown.
  `VVPE_ASSERT_ANY(a_reset_quiet, !rst_n |=> !in_ready && !out_valid, "busy after reset")

  // A stalled result beat holds.
  `VVPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_peak_x) && $stable(out_peak_y) && $stable(out_peak_z) && $stable(out_cell_value) && $stable(out_found), "result changed under stall")

  // No peak: coordinates and flag are zero.
  `VVPE_ASSERT(a_nopeak_zero, out_valid && !out_found |-> out_peak_x == '0 && out_peak_y == '0 && out_peak_z == '0 && !out_above_threshold, "no-peak result not zero")

  // A found peak carries a non-zero value.
  `VVPE_ASSERT(a_found_value, out_valid && out_found |-> out_cell_value != '0, "peak with zero value")

  // Above threshold only for a found peak.
  `VVPE_ASSERT(a_above_found, out_valid && out_above_threshold |-> out_found, "threshold flag without peak")

endmodule

bind vote_volume_peak_extractor vvpe_checker u_vvpe_checker (.*);
